>>> hw/rtl/scba_pkg.sv
// scba_pkg: shared types, constants and helpers of the size-class block allocator
// no dependencies; imported by every module of the block
package scba_pkg;

	// size-class geometry
	localparam int CLASS_STEP     = 256;
	localparam int MAX_UNITS      = 8192;
	localparam int UNIT_BYTES     = 4;
	localparam int POOL_SIZE_DEF  = 256;
	localparam int ADDR_WIDTH_DEF = 32;

	// port field widths
	localparam int MODE_W      = 2;
	localparam int HANDLE_W    = 8;
	localparam int COUNT_W     = 14;
	localparam int BYTE_ADDR_W = 32;
	localparam int STATUS_W    = 3;

	// derived bucket geometry
	localparam int NBUCKETS     = (MAX_UNITS + CLASS_STEP - 1) / CLASS_STEP + 1;
	localparam int BKT_W        = $clog2(NBUCKETS);
	localparam int STEP_SH      = $clog2(CLASS_STEP);
	localparam int REGION_BYTES = CLASS_STEP * UNIT_BYTES;
	localparam int REGION_W     = $clog2((NBUCKETS - 1) * REGION_BYTES + 1);

	typedef logic [BKT_W-1:0] bucket_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_WRITE   = 2'd2,
		MODE_READ    = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_TOO_LARGE  = 3'd1,
		ST_ADDR_OVF   = 3'd2,
		ST_POOL_EMPTY = 3'd3,
		ST_READ_LONG  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_LOOKUP,
		SEQ_RELEASE,
		SEQ_POP,
		SEQ_FRESH
	} seq_state_t;

	// per-field write enables of the descriptor store
	typedef struct packed {
		logic link_we;
		logic off_we;
		logic units_we;
	} desc_we_t;

	// round a unit count up to its size class, clamped to the last bucket
	function automatic bucket_t bucket_of(logic [COUNT_W-1:0] n);
		logic [COUNT_W:0] r;
		r = {1'b0, n} + (COUNT_W + 1)'(CLASS_STEP - 1);
		r = r >> STEP_SH;
		if (r > (COUNT_W + 1)'(NBUCKETS - 1))
			return BKT_W'(NBUCKETS - 1);
		return BKT_W'(r);
	endfunction

	// byte size of one region of a bucket
	function automatic logic [REGION_W-1:0] region_bytes(bucket_t b);
		return REGION_W'(b) * REGION_W'(REGION_BYTES);
	endfunction

endpackage

>>> hw/rtl/scba_desc_store.sv
// scba_desc_store: descriptor memory (free-list link, byte offset, unit count)
// depends on scba_pkg; one registered read port, one write port with field enables
module scba_desc_store #(
	parameter int POOL_SIZE  = scba_pkg::POOL_SIZE_DEF,
	parameter int ADDR_WIDTH = scba_pkg::ADDR_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              rd_en,
	input  logic [$clog2(POOL_SIZE)-1:0]      rd_addr,
	output logic [$clog2(POOL_SIZE+1)-1:0]    rd_link,
	output logic [ADDR_WIDTH-1:0]             rd_off,
	output logic [scba_pkg::COUNT_W-1:0]      rd_units,
	input  scba_pkg::desc_we_t                we,
	input  logic [$clog2(POOL_SIZE)-1:0]      wr_addr,
	input  logic [$clog2(POOL_SIZE+1)-1:0]    wr_link,
	input  logic [ADDR_WIDTH-1:0]             wr_off,
	input  logic [scba_pkg::COUNT_W-1:0]      wr_units
);
	import scba_pkg::*;

	localparam int LINK_W = $clog2(POOL_SIZE + 1);

	logic [LINK_W-1:0]     link_mem  [POOL_SIZE];
	logic [ADDR_WIDTH-1:0] off_mem   [POOL_SIZE];
	logic [COUNT_W-1:0]    units_mem [POOL_SIZE];

	// link field
	always_ff @(posedge clk) begin
		if (we.link_we)
			link_mem[wr_addr] <= wr_link;
		if (rd_en)
			rd_link <= link_mem[rd_addr];
	end

	// byte offset field
	always_ff @(posedge clk) begin
		if (we.off_we)
			off_mem[wr_addr] <= wr_off;
		if (rd_en)
			rd_off <= off_mem[rd_addr];
	end

	// unit count field
	always_ff @(posedge clk) begin
		if (we.units_we)
			units_mem[wr_addr] <= wr_units;
		if (rd_en)
			rd_units <= units_mem[rd_addr];
	end

endmodule

>>> hw/rtl/scba_head_table.sv
// scba_head_table: per-bucket free-list head memory with reset-cleared valid bits
// depends on scba_pkg; an entry never written reads as the empty marker
module scba_head_table #(
	parameter int POOL_SIZE = scba_pkg::POOL_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  scba_pkg::bucket_t              rd_addr,
	output logic [$clog2(POOL_SIZE+1)-1:0] rd_head,
	input  logic                           wr_en,
	input  scba_pkg::bucket_t              wr_addr,
	input  logic [$clog2(POOL_SIZE+1)-1:0] wr_head
);
	import scba_pkg::*;

	localparam int LINK_W = $clog2(POOL_SIZE + 1);

	logic [LINK_W-1:0]   head_mem [NBUCKETS];
	logic [LINK_W-1:0]   rd_data_q;
	logic                rd_vld_q;
	logic [NBUCKETS-1:0] vld_q;

	// head storage, read-old on a same-address collision
	always_ff @(posedge clk) begin
		if (wr_en)
			head_mem[wr_addr] <= wr_head;
		rd_data_q <= head_mem[rd_addr];
	end

	// valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_head = rd_vld_q ? rd_data_q : LINK_W'(POOL_SIZE);

endmodule

>>> hw/rtl/size_class_block_allocator_core.sv
// size_class_block_allocator_core: size-class allocator with per-bucket LIFO free lists
// steps: read-check, in-class write, allocate from fresh space and errors end in the
// lookup state; allocate from a free list goes on to pop, release to release, and a
// write that changes size class to release and then pop or fresh. a new transaction
// is taken in the result cycle; the steps wait on registered head and descriptor reads.
// reset: control cleared at once, bucket heads marked empty by valid bits, no clearing pass
module size_class_block_allocator_core #(
	parameter int POOL_SIZE  = scba_pkg::POOL_SIZE_DEF,
	parameter int ADDR_WIDTH = scba_pkg::ADDR_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [scba_pkg::MODE_W-1:0]      mode,
	input  logic [scba_pkg::HANDLE_W-1:0]    handle,
	input  logic [scba_pkg::COUNT_W-1:0]     count,
	output logic                             busy,
	output logic                             done,
	output logic [scba_pkg::HANDLE_W-1:0]    result_handle,
	output logic [scba_pkg::BYTE_ADDR_W-1:0] byte_address,
	output logic [scba_pkg::COUNT_W-1:0]     stored_count,
	output logic [scba_pkg::STATUS_W-1:0]    status
);
	import scba_pkg::*;

	localparam int IDX_W  = $clog2(POOL_SIZE);
	localparam int LINK_W = $clog2(POOL_SIZE + 1);

	// handle reduction modulo the pool size
	logic [IDX_W-1:0] hmod_tab [2**HANDLE_W];
	for (genvar i = 0; i < 2**HANDLE_W; i++) begin : g_hmod
		assign hmod_tab[i] = IDX_W'(i % POOL_SIZE);
	end

	// control and item registers
	seq_state_t          state_q, state_d;
	mode_t               mode_q;
	logic [IDX_W-1:0]    h_q;
	logic [COUNT_W-1:0]  n_q;
	bucket_t             bn_q, bo_q;
	logic [LINK_W-1:0]   head_bn_q, head_bo_q;
	logic [LINK_W-1:0]   fresh_q;
	logic [ADDR_WIDTH-1:0] store_end_q;

	// result registers
	logic                   done_q;
	logic [HANDLE_W-1:0]    rh_q;
	logic [BYTE_ADDR_W-1:0] baddr_q;
	logic [COUNT_W-1:0]     scount_q;
	status_t                status_q;

	// memory ports
	logic                  d_rd_en;
	logic [IDX_W-1:0]      d_rd_addr;
	logic [LINK_W-1:0]     d_rd_link;
	logic [ADDR_WIDTH-1:0] d_rd_off;
	logic [COUNT_W-1:0]    d_rd_units;
	desc_we_t              d_we;
	logic [IDX_W-1:0]      d_wr_addr;
	logic [LINK_W-1:0]     d_wr_link;
	logic [COUNT_W-1:0]    d_wr_units;
	bucket_t               t_rd_addr;
	logic [LINK_W-1:0]     head_rd;
	logic                  t_we;
	bucket_t               t_wr_addr;
	logic [LINK_W-1:0]     t_wr_head;

	// step decode
	logic                  out_ld;
	logic [IDX_W-1:0]      out_idx;
	logic [ADDR_WIDTH-1:0] out_off;
	logic [COUNT_W-1:0]    out_units;
	status_t               out_st;
	logic                  take_fresh;
	bucket_t               bo_c;
	logic                  n_big, bn_hit, pool_out;
	logic [ADDR_WIDTH:0]   next_ext;
	status_t               fresh_st;
	logic [IDX_W-1:0]      fresh_idx, top_idx;
	logic [LINK_W-1:0]     link_top;

	scba_desc_store #(
		.POOL_SIZE (POOL_SIZE),
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_desc (
		.clk     (clk),
		.rd_en   (d_rd_en),
		.rd_addr (d_rd_addr),
		.rd_link (d_rd_link),
		.rd_off  (d_rd_off),
		.rd_units(d_rd_units),
		.we      (d_we),
		.wr_addr (d_wr_addr),
		.wr_link (d_wr_link),
		.wr_off  (store_end_q),
		.wr_units(d_wr_units)
	);

	scba_head_table #(
		.POOL_SIZE(POOL_SIZE)
	) u_head (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_addr(t_rd_addr),
		.rd_head(head_rd),
		.wr_en  (t_we),
		.wr_addr(t_wr_addr),
		.wr_head(t_wr_head)
	);

	// size check, free-list hit and fresh-space checks against the end of store
	assign n_big     = n_q > COUNT_W'(MAX_UNITS);
	assign bn_hit    = head_rd < LINK_W'(POOL_SIZE);
	assign pool_out  = fresh_q >= LINK_W'(POOL_SIZE);
	assign next_ext  = {1'b0, store_end_q} + (ADDR_WIDTH + 1)'(region_bytes(bn_q));
	assign fresh_st  = pool_out ? ST_POOL_EMPTY : (next_ext[ADDR_WIDTH] ? ST_ADDR_OVF : ST_OK);
	assign fresh_idx = fresh_q[IDX_W-1:0];
	assign top_idx   = head_bn_q[IDX_W-1:0];
	assign bo_c      = bucket_of(d_rd_units);

	// popped link, forwarded when the block just released is the one popped
	always_comb begin
		if (mode_q == MODE_WRITE && top_idx == h_q)
			link_top = head_bo_q;
		else
			link_top = d_rd_link;
		if (link_top > LINK_W'(POOL_SIZE))
			link_top = LINK_W'(POOL_SIZE);
	end

	// sequencer: next state, memory accesses and result
	always_comb begin
		state_d    = state_q;
		d_rd_en    = 1'b0;
		d_rd_addr  = hmod_tab[handle];
		d_we       = '0;
		d_wr_addr  = h_q;
		d_wr_link  = head_rd;
		d_wr_units = n_q;
		t_rd_addr  = bucket_of(count);
		t_we       = 1'b0;
		t_wr_addr  = bn_q;
		t_wr_head  = link_top;
		out_ld     = 1'b0;
		out_idx    = h_q;
		out_off    = d_rd_off;
		out_units  = d_rd_units;
		out_st     = ST_OK;
		take_fresh = 1'b0;
		case (state_q)
			SEQ_IDLE: begin
				if (start) begin
					d_rd_en = 1'b1;
					state_d = SEQ_LOOKUP;
				end
			end
			SEQ_LOOKUP: begin
				case (mode_q)
					MODE_ALLOC: begin
						if (n_big || (!bn_hit && fresh_st != ST_OK)) begin
							out_ld    = 1'b1;
							out_idx   = '0;
							out_off   = '0;
							out_units = '0;
							out_st    = n_big ? ST_TOO_LARGE : fresh_st;
							state_d   = SEQ_IDLE;
						end else if (bn_hit) begin
							d_rd_en   = 1'b1;
							d_rd_addr = head_rd[IDX_W-1:0];
							state_d   = SEQ_POP;
						end else begin
							d_we       = '{link_we: 1'b0, off_we: 1'b1, units_we: 1'b1};
							d_wr_addr  = fresh_idx;
							take_fresh = 1'b1;
							out_ld     = 1'b1;
							out_idx    = fresh_idx;
							out_off    = store_end_q;
							out_units  = n_q;
							state_d    = SEQ_IDLE;
						end
					end
					MODE_RELEASE: begin
						t_rd_addr = bo_c;
						state_d   = SEQ_RELEASE;
					end
					MODE_WRITE: begin
						if (n_big) begin
							out_ld  = 1'b1;
							out_st  = ST_TOO_LARGE;
							state_d = SEQ_IDLE;
						end else if (bo_c == bn_q) begin
							d_we      = '{link_we: 1'b0, off_we: 1'b0, units_we: 1'b1};
							out_ld    = 1'b1;
							out_units = n_q;
							state_d   = SEQ_IDLE;
						end else if (!bn_hit && fresh_st != ST_OK) begin
							out_ld  = 1'b1;
							out_st  = fresh_st;
							state_d = SEQ_IDLE;
						end else begin
							t_rd_addr = bo_c;
							state_d   = SEQ_RELEASE;
						end
					end
					default: begin
						out_ld  = 1'b1;
						out_st  = (n_q > d_rd_units) ? ST_READ_LONG : ST_OK;
						state_d = SEQ_IDLE;
					end
				endcase
			end
			SEQ_RELEASE: begin
				// push the handle onto its old bucket
				d_we      = '{link_we: 1'b1, off_we: 1'b0, units_we: 1'b0};
				t_we      = 1'b1;
				t_wr_addr = bo_q;
				t_wr_head = LINK_W'(h_q);
				if (mode_q == MODE_RELEASE) begin
					out_ld  = 1'b1;
					state_d = SEQ_IDLE;
				end else if (head_bn_q < LINK_W'(POOL_SIZE)) begin
					d_rd_en   = 1'b1;
					d_rd_addr = top_idx;
					state_d   = SEQ_POP;
				end else begin
					state_d = SEQ_FRESH;
				end
			end
			SEQ_POP: begin
				t_we      = 1'b1;
				t_wr_addr = bn_q;
				d_we      = '{link_we: 1'b0, off_we: 1'b0, units_we: 1'b1};
				d_wr_addr = top_idx;
				out_ld    = 1'b1;
				out_idx   = top_idx;
				out_units = n_q;
				state_d   = SEQ_IDLE;
			end
			SEQ_FRESH: begin
				d_we       = '{link_we: 1'b0, off_we: 1'b1, units_we: 1'b1};
				d_wr_addr  = fresh_idx;
				take_fresh = 1'b1;
				out_ld     = 1'b1;
				out_idx    = fresh_idx;
				out_off    = store_end_q;
				out_units  = n_q;
				state_d    = SEQ_IDLE;
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			fresh_q     <= '0;
			store_end_q <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= out_ld;
			if (take_fresh) begin
				fresh_q     <= fresh_q + LINK_W'(1);
				store_end_q <= next_ext[ADDR_WIDTH-1:0];
			end
		end
	end

	// item payload captured along the sequence
	always_ff @(posedge clk) begin
		if (state_q == SEQ_IDLE && start) begin
			mode_q <= mode_t'(mode);
			h_q    <= hmod_tab[handle];
			n_q    <= count;
			bn_q   <= bucket_of(count);
		end
		if (state_q == SEQ_LOOKUP) begin
			bo_q      <= bo_c;
			head_bn_q <= head_rd;
		end
		if (state_q == SEQ_RELEASE)
			head_bo_q <= head_rd;
	end

	// result registers
	always_ff @(posedge clk) begin
		if (out_ld) begin
			rh_q     <= HANDLE_W'(out_idx);
			baddr_q  <= BYTE_ADDR_W'(out_off);
			scount_q <= out_units;
			status_q <= out_st;
		end
	end

	assign busy          = state_q != SEQ_IDLE;
	assign done          = done_q;
	assign result_handle = rh_q;
	assign byte_address  = baddr_q;
	assign stored_count  = scount_q;
	assign status        = status_q;

endmodule

>>> hw/rtl/scba_checker.sv
// scba_checker: port-level checks of the size-class block allocator
// depends on scba_pkg; bound to size_class_block_allocator_core below
module scba_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic [scba_pkg::MODE_W-1:0]      mode,
	input logic                             busy,
	input logic                             done,
	input logic [scba_pkg::STATUS_W-1:0]    status
);
	import scba_pkg::*;

	logic [MODE_W-1:0] acc_mode_q;

	// mode of the transaction in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_mode_q <= MODE_ALLOC;
		else if (start && !busy)
			acc_mode_q <= mode;
	end

	// a result only shows once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	// an accepted transaction occupies the block and has no result next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done)) else $error("accept did not start work");

	// every finished transaction gives its result
	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("work ended without result");

	// read-check reports only ok or read too long
	a_read_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && acc_mode_q == MODE_READ) |-> (status == ST_OK || status == ST_READ_LONG))
		else $error("bad status on read-check");

	// release never fails
	a_release_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && acc_mode_q == MODE_RELEASE) |-> (status == ST_OK))
		else $error("bad status on release");

endmodule

bind size_class_block_allocator_core scba_checker u_scba_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.mode  (mode),
	.busy  (busy),
	.done  (done),
	.status(status)
);
